>>> rtl/assert_macros.svh
// Assertion helpers for the checker, included by rle_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define RLE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define RLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rle_pkg.sv
package rle_pkg;

   localparam int BITS_PER_FRAME = 24;
   localparam int COLOR_W        = 8;
   localparam int TICK_W         = 15;
   localparam int CNT_W          = $clog2(BITS_PER_FRAME + 1);
   localparam int PADDR_W        = 5;
   localparam int PDATA_W        = 32;

   typedef logic [COLOR_W-1:0]    color_type;
   typedef logic [TICK_W-1:0]     tick_type;
   typedef logic [PADDR_W-1:0]    paddr_type;
   typedef logic [PDATA_W-1:0]    pdata_type;
   typedef logic [BITS_PER_FRAME-1:0] frame_type;

   // Register index, taken from paddr[4:2]
   typedef enum logic [2:0] {
      REG_BRIGHTNESS = 3'd0,
      REG_ONE_HIGH   = 3'd1,
      REG_ONE_LOW    = 3'd2,
      REG_ZERO_HIGH  = 3'd3,
      REG_ZERO_LOW   = 3'd4
   } reg_index_type;

   localparam color_type BRIGHTNESS_RST = 8'd128;
   localparam tick_type  ONE_HIGH_RST   = 15'd8;
   localparam tick_type  ONE_LOW_RST    = 15'd4;
   localparam tick_type  ZERO_HIGH_RST  = 15'd4;
   localparam tick_type  ZERO_LOW_RST   = 15'd9;

   typedef struct packed {
      color_type brightness;
      tick_type  one_high;
      tick_type  one_low;
      tick_type  zero_high;
      tick_type  zero_low;
   } cfg_type;

endpackage

>>> rtl/rle_if.sv
// Command channel: one word per color command.
interface rle_req_if;
   logic                valid;
   logic                ready;
   logic                func;
   rle_pkg::color_type  red_in;
   rle_pkg::color_type  green_in;
   rle_pkg::color_type  blue_in;

   modport source (output valid, func, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, func, red_in, green_in, blue_in, output ready);
endinterface

// Symbol channel: one word per pulse symbol.
interface rle_rsp_if;
   logic                valid;
   logic                ready;
   logic                bit_value;
   rle_pkg::tick_type   high_ticks;
   rle_pkg::tick_type   low_ticks;
   logic                last_symbol;

   modport source (output valid, bit_value, high_ticks, low_ticks, last_symbol, input ready);
   modport sink   (input valid, bit_value, high_ticks, low_ticks, last_symbol, output ready);
endinterface

>>> rtl/rgb_led_pulse_encoder.sv
// RGB LED pulse encoder. Each command word (new color or resend of the stored
// color) yields 24 symbol words, green, red, blue, MSB first, each channel
// scaled by brightness/255. The symbol serializer emits one word per cycle
// while the symbol sink is ready, and the next command is taken while the
// current frame is still going out. A command passes the multiply stage, the
// merge and the output register before its first symbol appears. Registers:
// brightness at 0x00, one high/low ticks at 0x04/0x08, zero high/low ticks at
// 0x0C/0x10; write them only while idle.
module rgb_led_pulse_encoder (
   input  logic                clock,
   input  logic                reset,
   rle_req_if.sink             req,
   rle_rsp_if.source           rsp,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  rle_pkg::paddr_type  paddr,
   input  rle_pkg::pdata_type  pwdata,
   output rle_pkg::pdata_type  prdata,
   output logic                pready
);
   import rle_pkg::*;

   cfg_type   cfg;
   logic      s1_valid_ff, s1_valid_in;
   logic      frame_take, accept;
   color_type red_s, green_s, blue_s;

   rle_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Take a word when the product stage is free or moving on
   assign req.ready   = ~s1_valid_ff | frame_take;
   assign accept      = req.valid & req.ready;
   assign s1_valid_in = accept | (s1_valid_ff & ~frame_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   rle_lane u_lane_red (
      .clock (clock), .reset (reset), .load (accept), .func (req.func),
      .color_in (req.red_in), .brightness (cfg.brightness), .scaled (red_s)
   );

   rle_lane u_lane_green (
      .clock (clock), .reset (reset), .load (accept), .func (req.func),
      .color_in (req.green_in), .brightness (cfg.brightness), .scaled (green_s)
   );

   rle_lane u_lane_blue (
      .clock (clock), .reset (reset), .load (accept), .func (req.func),
      .color_in (req.blue_in), .brightness (cfg.brightness), .scaled (blue_s)
   );

   rle_serializer u_ser (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .frame_valid (s1_valid_ff),
      .green       (green_s),
      .red         (red_s),
      .blue        (blue_s),
      .frame_take  (frame_take),
      .rsp         (rsp)
   );

endmodule

>>> rtl/rle_csr.sv
module rle_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  rle_pkg::paddr_type  paddr,
   input  rle_pkg::pdata_type  pwdata,
   output rle_pkg::pdata_type  prdata,
   output logic                pready,
   output rle_pkg::cfg_type    cfg
);
   import rle_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[PADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Decode the write; unknown indexes drop the word
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_BRIGHTNESS: cfg_in.brightness = pwdata[COLOR_W-1:0];
            REG_ONE_HIGH:   cfg_in.one_high   = pwdata[TICK_W-1:0];
            REG_ONE_LOW:    cfg_in.one_low    = pwdata[TICK_W-1:0];
            REG_ZERO_HIGH:  cfg_in.zero_high  = pwdata[TICK_W-1:0];
            REG_ZERO_LOW:   cfg_in.zero_low   = pwdata[TICK_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brightness <= BRIGHTNESS_RST;
         cfg_ff.one_high   <= ONE_HIGH_RST;
         cfg_ff.one_low    <= ONE_LOW_RST;
         cfg_ff.zero_high  <= ZERO_HIGH_RST;
         cfg_ff.zero_low   <= ZERO_LOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back, zero extended
   always_comb begin
      unique case (idx)
         REG_BRIGHTNESS: prdata = PDATA_W'(cfg_ff.brightness);
         REG_ONE_HIGH:   prdata = PDATA_W'(cfg_ff.one_high);
         REG_ONE_LOW:    prdata = PDATA_W'(cfg_ff.one_low);
         REG_ZERO_HIGH:  prdata = PDATA_W'(cfg_ff.zero_high);
         REG_ZERO_LOW:   prdata = PDATA_W'(cfg_ff.zero_low);
         default:        prdata = '0;
      endcase
   end

endmodule

>>> rtl/rle_lane.sv
module rle_lane (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                func,
   input  rle_pkg::color_type  color_in,
   input  rle_pkg::color_type  brightness,
   output rle_pkg::color_type  scaled
);
   import rle_pkg::*;

   color_type                 stored_ff, stored_in;
   color_type                 src;
   logic [2*COLOR_W-1:0]      prod_ff, prod_in;
   logic [2*COLOR_W:0]        div_sum;

   // Keep the channel of a new-color word, reuse it on resend
   assign stored_in = (load && !func) ? color_in : stored_ff;
   assign src       = func ? stored_ff : color_in;
   assign prod_in   = load ? (2*COLOR_W)'(src) * (2*COLOR_W)'(brightness) : prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff <= '0;
      end else begin
         stored_ff <= stored_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Divide by 255: (p + p/256 + 1) / 256 is exact for any 8x8 product
   assign div_sum = (2*COLOR_W+1)'(prod_ff) + (2*COLOR_W+1)'(prod_ff >> COLOR_W)
                  + (2*COLOR_W+1)'(1);
   assign scaled  = div_sum[2*COLOR_W-1:COLOR_W];

endmodule

>>> rtl/rle_serializer.sv
module rle_serializer (
   input  logic                clock,
   input  logic                reset,
   input  rle_pkg::cfg_type    cfg,
   input  logic                frame_valid,
   input  rle_pkg::color_type  green,
   input  rle_pkg::color_type  red,
   input  rle_pkg::color_type  blue,
   output logic                frame_take,
   rle_rsp_if.source           rsp
);
   import rle_pkg::*;

   frame_type        shift_ff, shift_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic             out_valid_ff, out_valid_in;
   logic             bit_ff, last_ff;
   tick_type         high_ff, low_ff;
   logic             emit, load_ready;

   // Merge the lanes and count symbols out
   always_comb begin
      emit         = (rem_ff != '0) && (!out_valid_ff || rsp.ready);
      load_ready   = (rem_ff == '0) || ((rem_ff == CNT_W'(1)) && emit);
      frame_take   = frame_valid && load_ready;
      rem_in       = rem_ff;
      shift_in     = shift_ff;
      if (frame_take) begin
         rem_in   = CNT_W'(BITS_PER_FRAME);
         shift_in = {green, red, blue};
      end else if (emit) begin
         rem_in   = rem_ff - CNT_W'(1);
         shift_in = shift_ff << 1;
      end
      out_valid_in = emit | (out_valid_ff & ~rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output word: bit, its timing and the end-of-frame flag
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (emit) begin
         bit_ff  <= shift_ff[BITS_PER_FRAME-1];
         high_ff <= shift_ff[BITS_PER_FRAME-1] ? cfg.one_high : cfg.zero_high;
         low_ff  <= shift_ff[BITS_PER_FRAME-1] ? cfg.one_low : cfg.zero_low;
         last_ff <= (rem_ff == CNT_W'(1));
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.bit_value   = bit_ff;
   assign rsp.high_ticks  = high_ff;
   assign rsp.low_ticks   = low_ff;
   assign rsp.last_symbol = last_ff;

endmodule

>>> rtl/rle_checker.sv
`include "assert_macros.svh"

module rle_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_bit_value,
   input rle_pkg::tick_type  rsp_high_ticks,
   input rle_pkg::tick_type  rsp_low_ticks,
   input logic               rsp_last_symbol,
   input logic               pready
);
   import rle_pkg::*;

   logic rsp_hs;
   logic last_hs;

   assign rsp_hs  = rsp_valid & rsp_ready;
   assign last_hs = rsp_hs & rsp_last_symbol;

   // A stalled symbol word holds
   `RLE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_bit_value, rsp_high_ticks, rsp_low_ticks, rsp_last_symbol}), "stalled symbol changed")
   // No symbol word right after reset
   `RLE_ASSERT_ALWAYS(a_rst_quiet, clock, $past(reset) |-> !rsp_valid, "symbol valid after reset")
   // Frames are many symbols long: no two ends back to back
   `RLE_ASSERT(a_frame_len, clock, reset, last_hs |-> !$past(last_hs), "frame end on consecutive symbols")
   // Register port never waits
   `RLE_ASSERT_ALWAYS(a_pready, clock, pready, "pready low")

endmodule

bind rgb_led_pulse_encoder rle_checker u_rle_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_bit_value   (rsp.bit_value),
   .rsp_high_ticks  (rsp.high_ticks),
   .rsp_low_ticks   (rsp.low_ticks),
   .rsp_last_symbol (rsp.last_symbol),
   .pready          (pready)
);
